### design/quintic_trajectory_eval_top_macros.svh
// Assertion macros shared by the trajectory evaluator modules.
`ifndef QUINTIC_TRAJECTORY_EVAL_TOP_MACROS_SVH
`define QUINTIC_TRAJECTORY_EVAL_TOP_MACROS_SVH
`ifndef SYNTH
`define QTE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define QTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QTE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define QTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### design/qte_pkg.sv
`default_nettype none
package qte_pkg;

  localparam int DUR_W       = 24;
  localparam int CFG_DW      = 32;
  localparam int CFG_IW      = 3;
  localparam int COEF_W      = 64;
  localparam int OUT_W       = 48;
  localparam int NUM_DER     = 5;
  localparam int TDATA_W     = OUT_W * NUM_DER;
  localparam int S_W         = 56;
  localparam int DQ_W        = 63;
  localparam int QUEUE_DEPTH = 4;

  // Pipeline depths of the arithmetic units.
  localparam int MUL_LAT   = 4;
  localparam int HSTEP_LAT = MUL_LAT + 1;
  localparam int DDIV_LAT  = DQ_W + 2;
  localparam int SDIV_LAT  = S_W;

  typedef enum logic [CFG_IW-1:0] {
    REG_X0  = 3'd0,
    REG_V0  = 3'd1,
    REG_A0  = 3'd2,
    REG_X1  = 3'd3,
    REG_V1  = 3'd4,
    REG_A1  = 3'd5,
    REG_DUR = 3'd6
  } reg_idx_t;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t ctab_t [NUM_DER][6];

  typedef struct packed {
    logic             bad;
    logic [DUR_W-1:0] t;
  } item_t;

  typedef struct packed {
    logic             busy;
    logic [DUR_W-1:0] dur;
  } stat_t;

  function automatic int lane_lat(input int m);
    return (NUM_DER - m) * HSTEP_LAT + m * DDIV_LAT;
  endfunction

  localparam int LANE_LAT_MAX = lane_lat(NUM_DER - 1);

  // Factor (j+1)(j+2)...(j+m) that the m-th derivative puts on coefficient j+m.
  function automatic logic [6:0] ffact(input int m, input int j);
    int f;
    f = 1;
    for (int i = 1; i <= m; i++) f = f * (j + i);
    if (j + m > 5) f = 0;
    return 7'(f);
  endfunction

endpackage
`default_nettype wire

### design/quintic_trajectory_eval_top.sv
`default_nettype none
// Quintic trajectory evaluator. Program the six boundary registers and the duration
// through the write port; after reset and after any register write the block solves
// the six quintic coefficients with one shared 64-bit multiplier, and items arriving
// then wait in the input queue. Afterwards it takes one sample time per cycle while
// the output is not stalled and returns position and its first four derivatives in
// signed Q32.16 plus overflow and zero-duration flags, one result per item. Between
// an item and its result lie 56 stages of the sample-time divider, 265 stages of the
// snap lane (one Horner step and four bit-per-stage divisions by the duration) and
// the output register. A stalled output freezes the evaluation pipeline while the
// input queue keeps accepting until it is full.
module quintic_trajectory_eval_top #(
  parameter int QDEPTH = qte_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [qte_pkg::DUR_W-1:0]     in_tdata,   // [23:0] sample_time
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [47:0] position, [95:48] velocity, [143:96] acceleration, [191:144] jerk,
  // [239:192] snap
  output logic [qte_pkg::TDATA_W-1:0]   out_tdata,
  output logic [1:0]                    out_tuser,  // [0] overflow, [1] bad_duration
  input  logic                          cfg_we,
  input  logic [qte_pkg::CFG_IW-1:0]    cfg_idx,
  input  logic [qte_pkg::CFG_DW-1:0]    cfg_wdata
);
  import qte_pkg::*;

  stat_t stat;
  ctab_t ctab;
  item_t head;
  logic  hvld, pop;

  qte_solve u_solve (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .stat_o    (stat),
    .ctab_o    (ctab)
  );

  qte_front #(.QDEPTH(QDEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .stat_i    (stat),
    .pop_i     (pop),
    .hvld_o    (hvld),
    .head_o    (head)
  );

  qte_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat_i     (stat),
    .ctab_i     (ctab),
    .hvld_i     (hvld),
    .head_i     (head),
    .pop_o      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

### design/qte_mul.sv
`default_nettype none
module qte_mul #(
  parameter int TW = 1
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [63:0]  a_i,
  input  logic signed [63:0]  b_i,
  input  logic [5:0]          sh_i,
  input  logic [TW-1:0]       tag_i,
  output logic signed [63:0]  p_o,
  output logic                ov_o,
  output logic [TW-1:0]       tag_o
);
  import qte_pkg::*;

  logic [63:0]  ua, ub;
  logic [63:0]  pp_r [4];
  logic         neg1_r, neg2_r, neg3_r;
  logic [5:0]   sh1_r, sh2_r;
  logic [TW-1:0] tag1_r, tag2_r, tag3_r, tag4_r;
  logic [127:0] prod2_r, rnd, sum3, shf3;
  logic [63:0]  mag3_r, lim, magc;
  logic         big3_r, negx, sat;
  logic signed [63:0] p4_r;
  logic         ov4_r;

  assign ua = a_i[63] ? 64'(-a_i) : 64'(a_i);
  assign ub = b_i[63] ? 64'(-b_i) : 64'(b_i);

  assign rnd  = (sh2_r == 6'd0) ? 128'd0 : (128'd1 << (sh2_r - 6'd1));
  assign sum3 = prod2_r + rnd;
  assign shf3 = sum3 >> sh2_r;

  assign negx = neg3_r && !(mag3_r == 64'd0 && !big3_r);
  assign lim  = negx ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
  assign sat  = big3_r || (mag3_r > lim);
  assign magc = sat ? lim : mag3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r[0] <= 64'(ua[31:0]) * 64'(ub[31:0]);
      pp_r[1] <= 64'(ua[31:0]) * 64'(ub[63:32]);
      pp_r[2] <= 64'(ua[63:32]) * 64'(ub[31:0]);
      pp_r[3] <= 64'(ua[63:32]) * 64'(ub[63:32]);
      neg1_r  <= a_i[63] ^ b_i[63];
      sh1_r   <= sh_i;
      tag1_r  <= tag_i;

      prod2_r <= {64'd0, pp_r[0]} + {32'd0, pp_r[1], 32'd0}
               + {32'd0, pp_r[2], 32'd0} + {pp_r[3], 64'd0};
      neg2_r  <= neg1_r;
      sh2_r   <= sh1_r;
      tag2_r  <= tag1_r;

      mag3_r  <= shf3[63:0];
      big3_r  <= |shf3[127:64];
      neg3_r  <= neg2_r;
      tag3_r  <= tag2_r;

      p4_r    <= negx ? $signed(64'(-magc)) : $signed(magc);
      ov4_r   <= sat;
      tag4_r  <= tag3_r;
    end
  end

  assign p_o   = p4_r;
  assign ov_o  = ov4_r;
  assign tag_o = tag4_r;

endmodule
`default_nettype wire

### design/qte_div.sv
`default_nettype none
module qte_div #(
  parameter int QW = 56,
  parameter int TW = 1
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [qte_pkg::DUR_W-1:0]    rem_i,
  input  logic [QW-1:0]                num_i,
  input  logic [qte_pkg::DUR_W-1:0]    d_i,
  input  logic [TW-1:0]                tag_i,
  output logic [QW-1:0]                q_o,
  output logic [TW-1:0]                tag_o
);
  import qte_pkg::*;

  logic [DUR_W-1:0] rem_r [QW];
  logic [QW-1:0]    nq_r  [QW];
  logic [TW-1:0]    tag_r [QW];

  // One quotient bit per stage; the numerator shifts out as the quotient shifts in.
  for (genvar i = 0; i < QW; i++) begin : g_st
    logic [DUR_W-1:0] rin;
    logic [QW-1:0]    nin;
    logic [TW-1:0]    tin;
    logic [DUR_W:0]   r1;
    logic             ge;
    if (i == 0) begin : g_first
      assign rin = rem_i;
      assign nin = num_i;
      assign tin = tag_i;
    end else begin : g_next
      assign rin = rem_r[i-1];
      assign nin = nq_r[i-1];
      assign tin = tag_r[i-1];
    end
    assign r1 = {rin, nin[QW-1]};
    assign ge = r1 >= {1'b0, d_i};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? DUR_W'(r1 - {1'b0, d_i}) : r1[DUR_W-1:0];
        nq_r[i]  <= {nin[QW-2:0], ge};
        tag_r[i] <= tin;
      end
    end
  end

  assign q_o   = nq_r[QW-1];
  assign tag_o = tag_r[QW-1];

endmodule
`default_nettype wire

### design/qte_front.sv
`default_nettype none
module qte_front #(
  parameter int QDEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [qte_pkg::DUR_W-1:0]  in_tdata,
  input  qte_pkg::stat_t             stat_i,
  input  logic                       pop_i,
  output logic                       hvld_o,
  output qte_pkg::item_t             head_o
);
  import qte_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  item_t         q_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          push;

  assign in_tready = cnt_r != CW'(QDEPTH);
  assign push      = in_tvalid && in_tready;
  assign hvld_o    = cnt_r != '0;
  assign head_o    = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      // A zero duration is flagged here; the back end then emits zeros.
      q_r[wp_r] <= '{bad: stat_i.dur == '0, t: in_tdata};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop_i) rp_r <= (rp_r == PW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (push && !pop_i) cnt_r <= cnt_r + 1'b1;
      else if (pop_i && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

### design/qte_solve.sv
`default_nettype none
`include "quintic_trajectory_eval_top_macros.svh"
module qte_solve (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [qte_pkg::CFG_IW-1:0]  cfg_idx,
  input  logic [qte_pkg::CFG_DW-1:0]  cfg_wdata,
  output qte_pkg::stat_t              stat_o,
  output qte_pkg::ctab_t              ctab_o
);
  import qte_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_ISSUE, S_WAIT, S_COMB, S_COEF, S_SCALE
  } state_t;

  typedef enum logic [2:0] {
    OP_P1, OP_P2, OP_AT, OP_E, OP_EH, OP_D
  } op_t;

  state_t state_r;
  op_t    op_r;
  logic   pend_r;
  logic signed [31:0] x0_r, v0_r, a0_r, x1_r, v1_r, a1_r;
  logic [DUR_W-1:0]   dur_r;
  logic [47:0]        t2_r;
  coef_t p1_r, p2_r, at_r, e_r, eh_r, d_r, h_r;
  coef_t c_r [6];
  ctab_t ctab_r;

  coef_t x0e, x1e, v0e, v1e, a0e, da, dv, dure, t2e;
  coef_t ma, mb, mp;
  logic [5:0] msh;
  logic  mov, mtag_o;

  assign x0e  = 64'(x0_r);
  assign x1e  = 64'(x1_r);
  assign v0e  = 64'(v0_r);
  assign v1e  = 64'(v1_r);
  assign a0e  = 64'(a0_r);
  assign da   = 64'(a1_r) - a0e;
  assign dv   = v1e - v0e - at_r;
  assign dure = $signed({40'd0, dur_r});
  assign t2e  = $signed({16'd0, t2_r});

  always_comb begin
    case (op_r)
      OP_P1:   begin ma = v0e; mb = dure; msh = 6'd16; end
      OP_P2:   begin ma = a0e; mb = t2e;  msh = 6'd33; end
      OP_AT:   begin ma = a0e; mb = dure; msh = 6'd16; end
      OP_E:    begin ma = da;  mb = t2e;  msh = 6'd32; end
      OP_EH:   begin ma = da;  mb = t2e;  msh = 6'd33; end
      OP_D:    begin ma = dv;  mb = dure; msh = 6'd16; end
      default: begin ma = '0;  mb = '0;   msh = 6'd0;  end
    endcase
  end

  qte_mul #(.TW(1)) u_mul (
    .clk   (clk),
    .en    (1'b1),
    .a_i   (ma),
    .b_i   (mb),
    .sh_i  (msh),
    .tag_i (state_r == S_ISSUE),
    .p_o   (mp),
    .ov_o  (mov),
    .tag_o (mtag_o)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_P1;
      pend_r  <= 1'b1;
      x0_r    <= '0;
      v0_r    <= '0;
      a0_r    <= '0;
      x1_r    <= '0;
      v1_r    <= '0;
      a1_r    <= '0;
      dur_r   <= DUR_W'(65536);
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_X0:  begin x0_r  <= cfg_wdata; pend_r <= 1'b1; end
          REG_V0:  begin v0_r  <= cfg_wdata; pend_r <= 1'b1; end
          REG_A0:  begin a0_r  <= cfg_wdata; pend_r <= 1'b1; end
          REG_X1:  begin x1_r  <= cfg_wdata; pend_r <= 1'b1; end
          REG_V1:  begin v1_r  <= cfg_wdata; pend_r <= 1'b1; end
          REG_A1:  begin a1_r  <= cfg_wdata; pend_r <= 1'b1; end
          REG_DUR: begin dur_r <= cfg_wdata[DUR_W-1:0]; pend_r <= 1'b1; end
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (pend_r && !cfg_we) begin
            pend_r  <= 1'b0;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          t2_r    <= 48'(dur_r) * 48'(dur_r);
          op_r    <= OP_P1;
          state_r <= S_ISSUE;
        end
        S_ISSUE: state_r <= S_WAIT;
        S_WAIT: begin
          if (mtag_o) begin
            case (op_r)
              OP_P1:   p1_r <= mp;
              OP_P2:   p2_r <= mp;
              OP_AT:   at_r <= mp;
              OP_E:    e_r  <= mp;
              OP_EH:   eh_r <= mp;
              default: d_r  <= mp;
            endcase
            if (op_r == OP_D) begin
              state_r <= S_COMB;
            end else begin
              op_r    <= op_t'(op_r + 3'd1);
              state_r <= S_ISSUE;
            end
          end
        end
        S_COMB: begin
          h_r     <= x1e - x0e - p1_r - p2_r;
          state_r <= S_COEF;
        end
        S_COEF: begin
          // The boundary conditions bound these sums well inside 64 bits.
          c_r[0]  <= x0e;
          c_r[1]  <= p1_r;
          c_r[2]  <= p2_r;
          c_r[3]  <= h_r * 64'sd10 - d_r * 64'sd4 + eh_r;
          c_r[4]  <= d_r * 64'sd7 - h_r * 64'sd15 - e_r;
          c_r[5]  <= h_r * 64'sd6 - d_r * 64'sd3 + eh_r;
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          for (int m = 0; m < NUM_DER; m++) begin
            for (int j = 0; j < 6; j++) begin
              ctab_r[m][j] <= c_r[(j + m > 5) ? 5 : j + m]
                            * $signed({57'd0, ffact(m, j)});
            end
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign stat_o = '{busy: pend_r || (state_r != S_IDLE), dur: dur_r};
  assign ctab_o = ctab_r;

  `QTE_ASSERT_NEXT(a_write_starts_solve, clk, rst_n, cfg_we && cfg_idx <= REG_DUR, stat_o.busy, "register write did not start a solve")
  `QTE_ASSERT_NEXT(a_issue_then_wait, clk, rst_n, state_r == S_ISSUE, state_r == S_WAIT, "solver skipped its wait")
  `QTE_ASSERT_IMPL(a_result_in_wait, clk, rst_n, mtag_o && !mov, state_r == S_WAIT, "product arrived outside wait")

endmodule
`default_nettype wire

### design/qte_back.sv
`default_nettype none
`include "quintic_trajectory_eval_top_macros.svh"
module qte_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  qte_pkg::stat_t                stat_i,
  input  qte_pkg::ctab_t                ctab_i,
  input  logic                          hvld_i,
  input  qte_pkg::item_t                head_i,
  output logic                          pop_o,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [qte_pkg::TDATA_W-1:0]   out_tdata,
  output logic [1:0]                    out_tuser
);
  import qte_pkg::*;

  localparam int VL = SDIV_LAT + LANE_LAT_MAX;

  logic               en, issue;
  logic [VL-1:0]      vchain_r;
  logic [LANE_LAT_MAX-1:0] bchain_r;
  logic [S_W-1:0]     sq;
  logic               sbad;
  coef_t              lane_res [NUM_DER];
  logic               lane_ov  [NUM_DER];
  logic               out_valid_r;
  logic [TDATA_W-1:0] out_tdata_r, dat;
  logic [1:0]         out_tuser_r;
  logic               ovs;

  // The whole back end advances together unless a finished item is stuck.
  assign en    = !out_valid_r || out_tready;
  assign issue = hvld_i && !stat_i.busy && en;
  assign pop_o = issue;

  qte_div #(.QW(S_W), .TW(1)) u_sdiv (
    .clk   (clk),
    .en    (en),
    .rem_i ('0),
    .num_i ({head_i.t, 32'd0}),
    .d_i   (stat_i.dur),
    .tag_i (head_i.bad),
    .q_o   (sq),
    .tag_o (sbad)
  );

  for (genvar m = 0; m < NUM_DER; m++) begin : g_lane
    localparam int NH  = NUM_DER - m;
    localparam int PAD = LANE_LAT_MAX - lane_lat(m);

    coef_t          hacc_r [1:NH];
    logic [S_W-1:0] hs_r   [1:NH];
    logic           hov_r  [1:NH];
    coef_t          lv;
    logic           lov;

    // Horner steps: acc = acc * s + scaled coefficient.
    for (genvar k = 0; k < NH; k++) begin : g_h
      coef_t          ma, mp, qk, res;
      logic [S_W-1:0] ms, ts;
      logic           mo, mov, tov, ovf;
      logic [64:0]    sum;
      if (k == 0) begin : g_first
        assign ma = ctab_i[m][NUM_DER - m];
        assign ms = sq;
        assign mo = 1'b0;
      end else begin : g_next
        assign ma = hacc_r[k];
        assign ms = hs_r[k];
        assign mo = hov_r[k];
      end
      qte_mul #(.TW(S_W + 1)) u_mul (
        .clk   (clk),
        .en    (en),
        .a_i   (ma),
        .b_i   ($signed({8'd0, ms})),
        .sh_i  (6'd32),
        .tag_i ({mo, ms}),
        .p_o   (mp),
        .ov_o  (mov),
        .tag_o ({tov, ts})
      );
      assign qk  = ctab_i[m][NUM_DER - 1 - m - k];
      assign sum = {mp[63], mp} + {qk[63], qk};
      assign ovf = sum[64] != sum[63];
      assign res = ovf ? (sum[64] ? $signed(64'h8000_0000_0000_0000)
                                  : $signed(64'h7fff_ffff_ffff_ffff))
                       : $signed(sum[63:0]);
      always_ff @(posedge clk) begin
        if (en) begin
          hacc_r[k+1] <= res;
          hs_r[k+1]   <= ts;
          hov_r[k+1]  <= tov | mov | ovf;
        end
      end
    end

    if (m == 0) begin : g_nodiv
      assign lv  = hacc_r[NH];
      assign lov = hov_r[NH];
    end else begin : g_div
      coef_t dacc_r [1:m];
      logic  dov_r  [1:m];
      // Each pass divides by the duration: round(v * 2^16 / T), half away from zero.
      for (genvar k = 0; k < m; k++) begin : g_d
        coef_t             din;
        logic              dovin, tn, tb, to;
        logic [63:0]       dmag;
        logic [79:0]       dd;
        logic              an_r, ab_r, ao_r;
        logic [DUR_W-1:0]  arem_r;
        logic [DQ_W-1:0]   anum_r, dq;
        if (k == 0) begin : g_first
          assign din   = hacc_r[NH];
          assign dovin = hov_r[NH];
        end else begin : g_next
          assign din   = dacc_r[k];
          assign dovin = dov_r[k];
        end
        assign dmag = din[63] ? 64'(-din) : 64'(din);
        assign dd   = {dmag, 16'd0} + 80'(stat_i.dur >> 1);
        always_ff @(posedge clk) begin
          if (en) begin
            an_r   <= din[63];
            ab_r   <= DUR_W'(dd[79:DQ_W]) >= stat_i.dur;
            ao_r   <= dovin;
            arem_r <= DUR_W'(dd[79:DQ_W]);
            anum_r <= dd[DQ_W-1:0];
          end
        end
        qte_div #(.QW(DQ_W), .TW(3)) u_ddiv (
          .clk   (clk),
          .en    (en),
          .rem_i (arem_r),
          .num_i (anum_r),
          .d_i   (stat_i.dur),
          .tag_i ({an_r, ab_r, ao_r}),
          .q_o   (dq),
          .tag_o ({tn, tb, to})
        );
        always_ff @(posedge clk) begin
          if (en) begin
            if (tb) begin
              dacc_r[k+1] <= tn ? $signed(64'h8000_0000_0000_0000)
                                : $signed(64'h7fff_ffff_ffff_ffff);
            end else if (tn && dq != '0) begin
              dacc_r[k+1] <= $signed(64'(-{1'b0, dq}));
            end else begin
              dacc_r[k+1] <= $signed({1'b0, dq});
            end
            dov_r[k+1] <= to | tb;
          end
        end
      end
      assign lv  = dacc_r[m];
      assign lov = dov_r[m];
    end

    if (PAD == 0) begin : g_nopad
      assign lane_res[m] = lv;
      assign lane_ov[m]  = lov;
    end else begin : g_pad
      logic [COEF_W:0] pd_r [PAD];
      always_ff @(posedge clk) begin
        if (en) begin
          pd_r[0] <= {lov, lv};
          for (int i = 1; i < PAD; i++) pd_r[i] <= pd_r[i-1];
        end
      end
      assign lane_res[m] = $signed(pd_r[PAD-1][COEF_W-1:0]);
      assign lane_ov[m]  = pd_r[PAD-1][COEF_W];
    end
  end

  always_comb begin
    logic [COEF_W-OUT_W:0] hi;
    ovs = 1'b0;
    dat = '0;
    for (int m = 0; m < NUM_DER; m++) begin
      hi = lane_res[m][COEF_W-1:OUT_W-1];
      if (hi == '0 || hi == '1) begin
        dat[m*OUT_W +: OUT_W] = lane_res[m][OUT_W-1:0];
      end else begin
        ovs = 1'b1;
        dat[m*OUT_W +: OUT_W] = lane_res[m][COEF_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                                      : {1'b0, {(OUT_W-1){1'b1}}};
      end
      ovs = ovs | lane_ov[m];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bchain_r <= {bchain_r[LANE_LAT_MAX-2:0], sbad};
      if (bchain_r[LANE_LAT_MAX-1]) begin
        out_tdata_r <= '0;
        out_tuser_r <= 2'b10;
      end else begin
        out_tdata_r <= dat;
        out_tuser_r <= {1'b0, ovs};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vchain_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vchain_r    <= {vchain_r[VL-2:0], issue};
      out_valid_r <= vchain_r[VL-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `QTE_ASSERT_IMPL(a_bad_gives_zero, clk, rst_n, out_valid_r && out_tuser_r[1], out_tdata_r == '0 && !out_tuser_r[0], "zero-duration item carries data")
  `QTE_ASSERT_IMPL(a_no_issue_busy, clk, rst_n, stat_i.busy, !pop_o, "item started during a coefficient solve")
  `QTE_ASSERT_NEXT(a_freeze_on_stall, clk, rst_n, out_valid_r && !out_tready, $stable(vchain_r), "pipeline moved while output stalled")

endmodule
`default_nettype wire

### tb/tb_quintic_trajectory_eval_top.sv
`timescale 1ns / 100ps
`default_nettype none

// Keeps its own copy of the boundary registers and the solved curve, works out
// the expected result for every accepted sample time and checks results in order.
class trajectory_scoreboard;
  localparam longint SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SMIN = 64'sh8000_0000_0000_0000;
  localparam longint OMAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint OMIN = -64'sh0000_8000_0000_0000;

  // Factor that the m-th derivative puts on each coefficient.
  int deriv_factor[5][6] = '{'{1, 1, 1, 1, 1, 1}, '{1, 2, 3, 4, 5, 0},
                             '{2, 6, 12, 20, 0, 0}, '{6, 24, 60, 0, 0, 0},
                             '{24, 120, 0, 0, 0, 0}};
  longint boundary[6];
  bit [63:0] dur;
  longint curve[6];
  bit curve_ok;
  logic [241:0] pending[$];
  int errors;
  int results;

  function new();
    foreach (boundary[i]) boundary[i] = 0;
    foreach (curve[i]) curve[i] = 0;
    dur = 64'd65536;
    curve_ok = 0;
    errors = 0;
    results = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] val);
    if (idx == qte_pkg::REG_DUR) begin
      dur = {40'd0, val[23:0]};
      curve_ok = 0;
    end else if (idx <= qte_pkg::REG_A1) begin
      boundary[idx] = longint'(signed'(val));
      curve_ok = 0;
    end
  endfunction

  function longint sign_mag(bit neg, bit [63:0] mag, bit big, inout bit ov);
    bit [63:0] lim;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (big || mag > lim) begin
      ov = 1;
      mag = lim;
    end
    return neg ? longint'(-mag) : longint'(mag);
  endfunction

  // round(a*b / 2^n), half away from zero, saturated.
  function longint scaled_mul(longint a, longint b, int n, inout bit ov);
    bit neg;
    bit [63:0] ua, ub;
    bit [127:0] p;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    if (n > 0) p = p + (128'd1 << (n - 1));
    p = p >> n;
    if (neg && p == 0) neg = 0;
    return sign_mag(neg, p[63:0], |p[127:64], ov);
  endfunction

  function longint add_sat(longint a, longint b, inout bit ov);
    logic [64:0] r;
    r = {a[63], a} + {b[63], b};
    if (r[64] != r[63]) begin
      ov = 1;
      return r[64] ? SMIN : SMAX;
    end
    return longint'(r[63:0]);
  endfunction

  function longint sub_sat(longint a, longint b, inout bit ov);
    logic [64:0] r;
    r = {a[63], a} - {b[63], b};
    if (r[64] != r[63]) begin
      ov = 1;
      return r[64] ? SMIN : SMAX;
    end
    return longint'(r[63:0]);
  endfunction

  function longint div_by_dur(longint v, inout bit ov);
    bit [63:0] mag, q, r, frac;
    mag = v < 0 ? -v : v;
    q = mag / dur;
    r = mag % dur;
    frac = ((r << 16) + dur / 2) / dur;
    if (q >= (64'd1 << 47)) return sign_mag(v < 0, 64'd0, 1, ov);
    return sign_mag(v < 0 && (q | frac) != 0, (q << 16) + frac, 0, ov);
  endfunction

  // Closed-form solve of the boundary conditions in normalized time.
  function void solve_curve();
    bit ov;
    longint tr, t2, p1, p2, h, dv, d, da, e, eh;
    ov = 0;
    tr = longint'(dur);
    t2 = tr * tr;
    p1 = scaled_mul(boundary[qte_pkg::REG_V0], tr, 16, ov);
    p2 = scaled_mul(boundary[qte_pkg::REG_A0], t2, 33, ov);
    h = sub_sat(sub_sat(sub_sat(boundary[qte_pkg::REG_X1], boundary[qte_pkg::REG_X0], ov),
                        p1, ov), p2, ov);
    dv = sub_sat(sub_sat(boundary[qte_pkg::REG_V1], boundary[qte_pkg::REG_V0], ov),
                 scaled_mul(boundary[qte_pkg::REG_A0], tr, 16, ov), ov);
    d = scaled_mul(dv, tr, 16, ov);
    da = sub_sat(boundary[qte_pkg::REG_A1], boundary[qte_pkg::REG_A0], ov);
    e = scaled_mul(da, t2, 32, ov);
    eh = scaled_mul(da, t2, 33, ov);
    curve[0] = boundary[qte_pkg::REG_X0];
    curve[1] = p1;
    curve[2] = p2;
    curve[3] = add_sat(sub_sat(scaled_mul(h, 10, 0, ov), scaled_mul(d, 4, 0, ov), ov), eh, ov);
    curve[4] = sub_sat(add_sat(scaled_mul(h, -15, 0, ov), scaled_mul(d, 7, 0, ov), ov), e, ov);
    curve[5] = add_sat(sub_sat(scaled_mul(h, 6, 0, ov), scaled_mul(d, 3, 0, ov), ov), eh, ov);
    curve_ok = 1;
  endfunction

  function void note_sample(logic [23:0] t);
    logic [239:0] data;
    bit ov;
    longint s, acc;
    data = '0;
    ov = 0;
    if (dur == 0) begin
      pending.push_back({1'b1, 1'b0, data});
      return;
    end
    if (!curve_ok) solve_curve();
    s = longint'(({40'd0, t} << 32) / dur);
    for (int m = 0; m < 5; m++) begin
      acc = scaled_mul(curve[5], deriv_factor[m][5 - m], 0, ov);
      for (int j = 4 - m; j >= 0; j--)
        acc = add_sat(scaled_mul(acc, s, 32, ov),
                      scaled_mul(curve[j + m], deriv_factor[m][j], 0, ov), ov);
      for (int k = 0; k < m; k++) acc = div_by_dur(acc, ov);
      if (acc > OMAX) begin
        acc = OMAX;
        ov = 1;
      end
      if (acc < OMIN) begin
        acc = OMIN;
        ov = 1;
      end
      data[m*48 +: 48] = acc[47:0];
    end
    pending.push_back({1'b0, ov, data});
  endfunction

  function void check_result(logic [239:0] data, logic [1:0] flags);
    string names[7] = '{"position", "velocity", "acceleration", "jerk", "snap",
                        "overflow", "bad_duration"};
    logic [241:0] exp_r;
    logic [47:0] e, a;
    results++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: result with nothing expected");
      return;
    end
    exp_r = pending.pop_front();
    for (int f = 0; f < 7; f++) begin
      e = f < 5 ? exp_r[f*48 +: 48] : 48'(exp_r[240 + f - 5]);
      a = f < 5 ? data[f*48 +: 48] : 48'(flags[f - 5]);
      if (e !== a) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result %0d %s expected %h got %h", results, names[f], e, a);
      end
    end
  endfunction
endclass

module tb_quintic_trajectory_eval_top;
  import qte_pkg::*;

  localparam logic [2:0] IDX_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;

  trajectory_scoreboard sb = new();
  bit no_idle = 0;
  int rx_hold = 0;
  int samples = 0;
  int settings = 1;

  quintic_trajectory_eval_top uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tuser);
      rx_hold = no_idle ? 0 : $urandom_range(0, 17);
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    #20ms;
    $display("tb_quintic_trajectory_eval_top failed");
    $finish;
  end

  task automatic send_sample(logic [23:0] t);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= t;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(t);
    samples++;
  endtask

  // Stops sending and lets every outstanding result come back.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_all(logic [31:0] x0, logic [31:0] v0, logic [31:0] a0,
                          logic [31:0] x1, logic [31:0] v1, logic [31:0] a1,
                          logic [23:0] t);
    write_reg(REG_X0, x0);
    write_reg(REG_V0, v0);
    write_reg(REG_A0, a0);
    write_reg(REG_X1, x1);
    write_reg(REG_V1, v1);
    write_reg(REG_A1, a1);
    write_reg(REG_DUR, {8'd0, t});
    settings++;
  endtask

  task automatic directed_samples(logic [23:0] t);
    send_sample(24'd0);
    send_sample(24'd1);
    send_sample(t);
    send_sample(t >> 1);
    send_sample(t + 24'd1);
    send_sample(24'hFFFFFF);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] pick_duration();
    case ($urandom_range(0, 9))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(1, 16));
      3, 4, 5: return 24'($urandom_range(24'h4000, 24'h4_0000));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_time(logic [23:0] t);
    case ($urandom_range(0, 7))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 64));
      2: return t + 24'($urandom_range(0, 4096));
      default: return 24'($urandom_range(0, t));
    endcase
  endfunction

  initial begin
    logic [23:0] t;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset state: the curve is flat at zero over one second.
    directed_samples(24'h010000);
    drain();
    load_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 24'hFFFFFF);
    directed_samples(24'hFFFFFF);
    drain();
    load_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 24'd1);
    directed_samples(24'd1);
    drain();
    // A zero duration gives only the flag; a write to the unused index changes nothing.
    write_reg(REG_DUR, 32'd0);
    write_reg(IDX_UNUSED, 32'h0001_0000);
    send_sample(24'h8000);
    send_sample(24'hFFFFFF);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      t = pick_duration();
      load_all(pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
               pick_value(), t);
      if ($urandom_range(0, 3) == 0) write_reg(IDX_UNUSED, $urandom);
      no_idle = (phase % 3 == 1);
      for (int n = 0; n < 170; n++) begin
        send_sample(pick_time(t));
        if (phase == 4 && n == 80) begin
          // Let the pipeline run empty in the middle of a burst.
          drain();
          no_idle = 0;
        end
      end
      drain();
    end

    $display("Checked %0d samples over %0d register settings, including zero and full",
             samples, settings);
    $display("duration, extreme boundaries and extrapolated sample times.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_quintic_trajectory_eval_top passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("tb_quintic_trajectory_eval_top failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

### filelist.f
+incdir+design
design/qte_pkg.sv
design/qte_mul.sv
design/qte_div.sv
design/qte_front.sv
design/qte_solve.sv
design/qte_back.sv
design/quintic_trajectory_eval_top.sv
tb/tb_quintic_trajectory_eval_top.sv
